/* rtl/core/isd_pkg.sv */
// ----------------------------------------------------------------------------
// isd_pkg
// Shared types, constants and helpers of the inverse S-function defuzzifier.
// ----------------------------------------------------------------------------
package isd_pkg;

  localparam int FracBitsDef = 16;
  localparam int MembW       = 17;
  localparam int GrayW       = 8;
  localparam int CfgIdxW     = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOW_KNEE  = 3'd0,
    CFG_MID_KNEE  = 3'd1,
    CFG_HIGH_KNEE = 3'd2,
    CFG_OUT_MIN   = 3'd3,
    CFG_OUT_MAX   = 3'd4
  } cfg_idx_e;

  // what the last stage puts on the output
  typedef enum logic [1:0] {
    KIND_CALC = 2'd0,
    KIND_MIN  = 2'd1,
    KIND_MAX  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e kind;
    logic  err;
    logic  upper;
  } isd_side_t;

  function automatic int isd_max(input int x, input int y);
    return (x > y) ? x : y;
  endfunction

endpackage

/* rtl/core/isd_sqrt.sv */
// ----------------------------------------------------------------------------
// isd_sqrt
// Pipelined floored integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module isd_sqrt import isd_pkg::*; #(
  parameter int VW = 33,
  parameter int RW = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  isd_side_t     side_i,
  input  logic [VW-1:0] rad_i,
  output logic          valid_o,
  output isd_side_t     side_o,
  output logic [RW-1:0] root_o
);

  localparam int IW = VW + 2;

  logic              val_q  [RW];
  isd_side_t         side_q [RW];
  logic [RW-1:0]     root_q [RW];
  logic [VW-1:0]     rem_q  [RW];

  logic [RW-1:0]     root_src [RW];
  logic [VW-1:0]     rem_src  [RW];
  logic [RW-1:0]     root_nxt [RW];
  logic [VW-1:0]     rem_nxt  [RW];

  // rem holds rad - root^2; trying bit k costs root*2^(k+1) + 2^(2k)
  always_comb begin
    logic [IW-1:0] incr;
    for (int s = 0; s < RW; s++) begin
      root_src[s] = (s == 0) ? '0 : root_q[(s == 0) ? 0 : s-1];
      rem_src[s]  = (s == 0) ? rad_i : rem_q[(s == 0) ? 0 : s-1];
      incr = (IW'(root_src[s]) << (RW - s)) | (IW'(1) << (2 * (RW - 1 - s)));
      if (IW'(rem_src[s]) >= incr) begin
        rem_nxt[s]  = VW'(IW'(rem_src[s]) - incr);
        root_nxt[s] = root_src[s] | (RW'(1) << (RW - 1 - s));
      end else begin
        rem_nxt[s]  = rem_src[s];
        root_nxt[s] = root_src[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < RW; s++) val_q[s] <= 1'b0;
    end else if (en_i) begin
      val_q[0] <= valid_i;
      for (int s = 1; s < RW; s++) val_q[s] <= val_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int s = 1; s < RW; s++) side_q[s] <= side_q[s-1];
      for (int s = 0; s < RW; s++) begin
        root_q[s] <= root_nxt[s];
        rem_q[s]  <= rem_nxt[s];
      end
    end
  end

  assign valid_o = val_q[RW-1];
  assign side_o  = side_q[RW-1];
  assign root_o  = root_q[RW-1];

endmodule

/* rtl/core/isd_div.sv */
// ----------------------------------------------------------------------------
// isd_div
// Pipelined restoring divider giving an 8-bit quotient, one bit per stage.
// ----------------------------------------------------------------------------
module isd_div import isd_pkg::*; #(
  parameter int NW = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  isd_side_t        side_i,
  input  logic [NW-1:0]    num_i,
  input  logic [GrayW-1:0] den_i,
  output logic             valid_o,
  output isd_side_t        side_o,
  output logic [GrayW-1:0] quot_o
);

  localparam int CW = NW + GrayW;

  logic             val_q  [GrayW];
  isd_side_t        side_q [GrayW];
  logic [NW-1:0]    rem_q  [GrayW];
  logic [GrayW-1:0] quo_q  [GrayW];

  logic [NW-1:0]    rem_src [GrayW];
  logic [GrayW-1:0] quo_src [GrayW];
  logic [NW-1:0]    rem_nxt [GrayW];
  logic [GrayW-1:0] quo_nxt [GrayW];

  // quotient never exceeds the span, so eight bits cover it
  always_comb begin
    logic [CW-1:0] dsh;
    for (int j = 0; j < GrayW; j++) begin
      rem_src[j] = (j == 0) ? num_i : rem_q[(j == 0) ? 0 : j-1];
      quo_src[j] = (j == 0) ? '0 : quo_q[(j == 0) ? 0 : j-1];
      dsh = CW'(den_i) << (GrayW - 1 - j);
      if (CW'(rem_src[j]) >= dsh) begin
        rem_nxt[j] = NW'(CW'(rem_src[j]) - dsh);
        quo_nxt[j] = quo_src[j] | (GrayW'(1) << (GrayW - 1 - j));
      end else begin
        rem_nxt[j] = rem_src[j];
        quo_nxt[j] = quo_src[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < GrayW; j++) val_q[j] <= 1'b0;
    end else if (en_i) begin
      val_q[0] <= valid_i;
      for (int j = 1; j < GrayW; j++) val_q[j] <= val_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int j = 1; j < GrayW; j++) side_q[j] <= side_q[j-1];
      for (int j = 0; j < GrayW; j++) begin
        rem_q[j] <= rem_nxt[j];
        quo_q[j] <= quo_nxt[j];
      end
    end
  end

  assign valid_o = val_q[GrayW-1];
  assign side_o  = side_q[GrayW-1];
  assign quot_o  = quo_q[GrayW-1];

endmodule

/* rtl/core/inverse_s_function_defuzzifier.sv */
// ----------------------------------------------------------------------------
// inverse_s_function_defuzzifier
// Maps a Q1.FRAC_BITS membership back to a gray level through the inverse
// S-curve set by the knee registers.
//
//   channel | direction | handshake            | payload
//   in      | sink      | in_valid_i/in_stall_o | membership_i
//   out     | source    | out_valid_o/out_stall_i | gray_out_o, knee_error_o
//   cfg     | sink      | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//
// one transaction per cycle while the output is not stalled; the pipe runs
// through the classify and radicand stages, the bit-serial root stages,
// the span scaling stage, the eight divider stages and the output register.
// reset clears all valid bits and loads the register defaults.
// a stalled valid output freezes the whole pipe; in_stall_o rises only then.
// ----------------------------------------------------------------------------
module inverse_s_function_defuzzifier import isd_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [GrayW-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [MembW-1:0]   membership_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [GrayW-1:0]   gray_out_o,
  output logic               knee_error_o
);

  localparam int H    = (FRAC_BITS + 1) / 2;
  localparam int ODD  = FRAC_BITS % 2;
  localparam int MXW  = isd_max(MembW, FRAC_BITS + 1);
  localparam int CMW  = isd_max(MembW, FRAC_BITS) + GrayW + 1;
  localparam int XW   = MXW + GrayW;
  localparam int VW   = XW + GrayW + ODD;
  localparam int RW   = (VW + 1) / 2;
  localparam int NUMW = isd_max(RW, GrayW + H);
  localparam int PW   = NUMW + GrayW;
  localparam int NW   = PW - H;

  logic [GrayW-1:0] a_q, b_q, c_q, omin_q, omax_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= GrayW'(0);
      b_q    <= GrayW'(128);
      c_q    <= GrayW'(255);
      omin_q <= GrayW'(0);
      omax_q <= GrayW'(255);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LOW_KNEE:  a_q    <= cfg_wdata_i;
        CFG_MID_KNEE:  b_q    <= cfg_wdata_i;
        CFG_HIGH_KNEE: c_q    <= cfg_wdata_i;
        CFG_OUT_MIN:   omin_q <= cfg_wdata_i;
        CFG_OUT_MAX:   omax_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // differences are only used when the knees are ordered
  logic [GrayW-1:0] ba, cb, ca, span;
  assign ba   = b_q - a_q;
  assign cb   = c_q - b_q;
  assign ca   = c_q - a_q;
  assign span = omax_q - omin_q;

  // stage 1: classify and form the first product
  isd_side_t     side1_d, side1_q;
  logic [XW-1:0] x_d, x_q;
  logic          v1_q;

  always_comb begin
    logic [MXW-1:0] m_ext;
    logic [MXW-1:0] one_c;
    logic           bad;
    m_ext = MXW'(membership_i);
    one_c = MXW'(1) << FRAC_BITS;
    bad   = !(a_q < b_q && b_q < c_q) || (omin_q > omax_q);
    side1_d.err   = bad;
    side1_d.upper = (CMW'(membership_i) * CMW'(ca)) > (CMW'(ba) << FRAC_BITS);
    if (bad || membership_i == '0) begin
      side1_d.kind = KIND_MIN;
    end else if (m_ext >= one_c) begin
      side1_d.kind = KIND_MAX;
    end else begin
      side1_d.kind = KIND_CALC;
    end
    if (side1_d.upper) begin
      x_d = XW'(one_c - m_ext) * XW'(cb);
    end else begin
      x_d = XW'(m_ext) * XW'(ba);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side1_q <= side1_d;
      x_q     <= x_d;
    end
  end

  // stage 2: radicand
  isd_side_t     side2_q;
  logic [VW-1:0] v_q;
  logic          v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side2_q <= side1_q;
      v_q     <= (VW'(x_q) * VW'(ca)) << ODD;
    end
  end

  logic          vs;
  isd_side_t     sides;
  logic [RW-1:0] root;

  isd_sqrt #(
    .VW (VW),
    .RW (RW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .side_i  (side2_q),
    .rad_i   (v_q),
    .valid_o (vs),
    .side_o  (sides),
    .root_o  (root)
  );

  // scale by the output span
  isd_side_t     sidep_q;
  logic [PW-1:0] p_q;
  logic          vp_q;
  logic [NUMW-1:0] num;

  always_comb begin
    logic [NUMW-1:0] den;
    logic [NUMW-1:0] r;
    den = NUMW'(ca) << H;
    r   = NUMW'(root);
    if (sides.upper) begin
      num = (r >= den) ? '0 : den - r;
    end else begin
      num = r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (en) begin
      vp_q <= vs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sidep_q <= sides;
      p_q     <= PW'(span) * PW'(num);
    end
  end

  logic             vd;
  isd_side_t        sided;
  logic [GrayW-1:0] quot;

  // floor(p / (ca << H)) equals floor((p >> H) / ca)
  isd_div #(
    .NW (NW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vp_q),
    .side_i  (sidep_q),
    .num_i   (NW'(p_q >> H)),
    .den_i   (ca),
    .valid_o (vd),
    .side_o  (sided),
    .quot_o  (quot)
  );

  logic [GrayW-1:0] gray_d, gray_q;
  logic             err_q;

  always_comb begin
    unique case (sided.kind)
      KIND_MIN:  gray_d = omin_q;
      KIND_MAX:  gray_d = omax_q;
      KIND_CALC: gray_d = omin_q + quot;
      default:   gray_d = omin_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gray_q <= gray_d;
      err_q  <= sided.err;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign gray_out_o   = gray_q;
  assign knee_error_o = err_q;

endmodule

/* rtl/core/isd_checker.sv */
// ----------------------------------------------------------------------------
// isd_checker
// Port-level assertions for the defuzzifier, bound to the top level.
// ----------------------------------------------------------------------------
module isd_checker import isd_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [MembW-1:0]   membership_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [GrayW-1:0]   gray_out_o,
  input logic               knee_error_o
);

  // the input side only backs up when a finished result is held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> (!out_valid_o && !in_stall_o))
    else $error("activity during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(gray_out_o) && $stable(knee_error_o)))
    else $error("stalled output payload changed");

  // a waiting input transaction is held unchanged
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(membership_i)))
    else $error("stalled input transaction changed");

endmodule

bind inverse_s_function_defuzzifier isd_checker u_isd_checker (.*);

/* dv/tb_inverse_s_function_defuzzifier.sv */
// ----------------------------------------------------------------------------
// tb_inverse_s_function_defuzzifier
// Self-checking bench for the inverse S-function defuzzifier: directed and
// random membership values under several knee settings, with random gaps,
// long output stalls and a drain pause, checked against an inline predictor.
// ----------------------------------------------------------------------------
module tb_inverse_s_function_defuzzifier;
  import isd_pkg::*;

  localparam int LATENCY = 60;

  typedef struct packed {
    logic [GrayW-1:0] gray;
    logic             err;
  } gray_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [GrayW-1:0]   cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [MembW-1:0]   membership_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [GrayW-1:0]   gray_out_o;
  logic               knee_error_o;

  logic [7:0] knee_a = 8'd0, knee_b = 8'd128, knee_c = 8'd255;
  logic [7:0] lvl_min = 8'd0, lvl_max = 8'd255;

  gray_result_t expected_grays[$];
  int  n_errors = 0;
  int  n_results = 0;
  int  n_sent = 0;
  bit  hold_off = 1'b0;
  bit  drain_stall = 1'b0;

  inverse_s_function_defuzzifier dut (.*);

  always #2 clk_i = ~clk_i;

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root, bitv;
    root = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic gray_result_t predict_gray(input logic [MembW-1:0] memb);
    gray_result_t res;
    logic [63:0] m, a, b, c, span, den, num, r, g;
    m = 64'(memb);
    a = 64'(knee_a);
    b = 64'(knee_b);
    c = 64'(knee_c);
    res.err = 1'b0;
    if (!(a < b && b < c) || lvl_min > lvl_max) begin
      g = 64'(lvl_min);
      res.err = 1'b1;
    end else if (m == 0) begin
      g = 64'(lvl_min);
    end else if (m >= 64'd65536) begin
      g = 64'(lvl_max);
    end else begin
      span = 64'(lvl_max) - 64'(lvl_min);
      den = (c - a) << 8;
      if (m * (c - a) <= ((b - a) << 16)) begin
        num = floor_sqrt(m * (b - a) * (c - a));
      end else begin
        r = floor_sqrt((64'd65536 - m) * (c - b) * (c - a));
        num = (r >= den) ? 64'd0 : den - r;
      end
      g = 64'(lvl_min) + (span * num) / den;
      if (g > 64'(lvl_max)) g = 64'(lvl_max);
    end
    res.gray = g[7:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, n_results);
    n_errors++;
  endtask

  task automatic idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return;
    repeat (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(negedge clk_i);
  endtask

  // one membership transaction; predictor runs when it is accepted
  task automatic send_membership(input logic [MembW-1:0] memb, input bit gaps);
    in_valid_i = 1'b1;
    membership_i = memb;
    do @(posedge clk_i); while (in_stall_o);
    expected_grays.push_back(predict_gray(memb));
    n_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    if (gaps) idle_gap();
  endtask

  task automatic wait_idle();
    while (expected_grays.size() != 0) @(negedge clk_i);
    repeat (LATENCY) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_LOW_KNEE:  knee_a = val;
      CFG_MID_KNEE:  knee_b = val;
      CFG_HIGH_KNEE: knee_c = val;
      CFG_OUT_MIN:   lvl_min = val;
      default:       lvl_max = val;
    endcase
  endtask

  task automatic set_knees(input logic [7:0] a, b, c, lo, hi);
    wait_idle();
    write_reg(CFG_LOW_KNEE, a);
    write_reg(CFG_MID_KNEE, b);
    write_reg(CFG_HIGH_KNEE, c);
    write_reg(CFG_OUT_MIN, lo);
    write_reg(CFG_OUT_MAX, hi);
  endtask

  function automatic logic [MembW-1:0] rand_membership();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 17'd0;
    if (r < 10) return 17'd65536 + 17'($urandom_range(0, 65535));
    if (r < 14) return 17'd65536;
    return 17'($urandom_range(1, 65535));
  endfunction

  task automatic test_directed_reset_knees();
    logic [MembW-1:0] vals [12];
    vals = '{17'd0, 17'd1, 17'd2, 17'd255, 17'd32767, 17'd32768, 17'd32769,
             17'd65534, 17'd65535, 17'd65536, 17'd65537, 17'h1FFFF};
    foreach (vals[i]) send_membership(vals[i], 1'b0);
  endtask

  task automatic test_bad_ordering();
    set_knees(8'd10, 8'd10, 8'd200, 8'd5, 8'd250);
    send_membership(17'd30000, 1'b0);
    set_knees(8'd10, 8'd100, 8'd100, 8'd5, 8'd250);
    send_membership(17'd65536, 1'b0);
    set_knees(8'd10, 8'd100, 8'd200, 8'd251, 8'd250);
    send_membership(17'd0, 1'b0);
    send_membership(17'd40000, 1'b0);
  endtask

  task automatic test_extreme_knees();
    set_knees(8'd0, 8'd1, 8'd2, 8'd0, 8'd255);
    send_membership(17'd32768, 1'b0);
    send_membership(17'd65535, 1'b0);
    set_knees(8'd253, 8'd254, 8'd255, 8'd255, 8'd255);
    send_membership(17'd1, 1'b0);
    send_membership(17'd50000, 1'b0);
  endtask

  task automatic test_random_settings();
    logic [7:0] a, b, c, lo, hi;
    for (int phase = 0; phase < 8; phase++) begin
      a = 8'($urandom_range(0, 253));
      b = 8'($urandom_range(int'(a) + 1, 254));
      c = 8'($urandom_range(int'(b) + 1, 255));
      lo = 8'($urandom_range(0, 255));
      hi = 8'($urandom_range(int'(lo), 255));
      if (phase == 7) begin
        // mostly disordered registers
        a = 8'($urandom); b = 8'($urandom); c = 8'($urandom);
        lo = 8'($urandom); hi = 8'($urandom);
      end
      set_knees(a, b, c, lo, hi);
      repeat (230) send_membership(rand_membership(), 1'b1);
    end
  endtask

  task automatic test_back_pressure();
    set_knees(8'd20, 8'd90, 8'd240, 8'd16, 8'd235);
    hold_off = 1'b1;
    repeat (120) send_membership(rand_membership(), 1'b0);
    // sender pauses until everything has drained
    while (expected_grays.size() != 0) @(negedge clk_i);
    repeat (20) send_membership(rand_membership(), 1'b0);
  endtask

  // receiver side: random stalls plus a long counted hold-off
  initial begin
    int cnt;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        for (cnt = 0; cnt < 200; cnt++) @(negedge clk_i);
        hold_off = 1'b0;
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 99) < 10) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(0, 99) < 90 ? $urandom_range(1, 3)
                                           : $urandom_range(10, 40)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    gray_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (expected_grays.size() == 0) begin
        report_mismatch("unexpected transaction", int'(gray_out_o), -1);
      end else begin
        want = expected_grays.pop_front();
        if (gray_out_o !== want.gray)
          report_mismatch("gray_out", int'(gray_out_o), int'(want.gray));
        if (knee_error_o !== want.err)
          report_mismatch("knee_error", int'(knee_error_o), int'(want.err));
      end
    end
  end

  initial begin
    #4000000;
    $display("tb_inverse_s_function_defuzzifier: errors");
    $finish;
  end

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_reset_knees();
    test_bad_ordering();
    test_extreme_knees();
    test_random_settings();
    test_back_pressure();
    wait_idle();
    $display("sent %0d memberships, checked %0d results", n_sent, n_results);
    $display("covered reset, extreme, disordered and random knees with stalls");
    if (n_errors == 0 && expected_grays.size() == 0) begin
      $display("tb_inverse_s_function_defuzzifier: clean");
    end else begin
      $display("tb_inverse_s_function_defuzzifier: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/isd_pkg.sv
rtl/core/isd_sqrt.sv
rtl/core/isd_div.sv
rtl/core/inverse_s_function_defuzzifier.sv
rtl/core/isd_checker.sv
dv/tb_inverse_s_function_defuzzifier.sv
